FILE: rtl/core/bba_pkg.sv
package bba_pkg;

  localparam int NUM_BLOCKS_DEF = 64;
  localparam int ADDR_BITS_DEF  = 32;

  localparam int BSIZE_W = 16;
  localparam int GUARD_W = 8;
  localparam int BCNT_W  = 7;
  localparam int BASE_W  = 32;
  localparam int PROD_W  = BCNT_W + BSIZE_W;

  localparam logic [1:0] OP_ALLOC    = 2'd0;
  localparam logic [1:0] OP_FREE     = 2'd1;
  localparam logic [1:0] OP_CONTAINS = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EXHAUST  = 2'd1;
  localparam logic [1:0] ST_REJECT   = 2'd2;
  localparam logic [1:0] ST_NOT_POOL = 2'd3;

  localparam logic [1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [1:0] REG_BLOCK_SIZE  = 2'd1;
  localparam logic [1:0] REG_GUARD_SIZE  = 2'd2;
  localparam logic [1:0] REG_BLOCK_COUNT = 2'd3;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_SCAN,
    S_AMUL,
    S_AADD,
    S_OFFS,
    S_RANGE,
    S_DIV,
    S_FRD,
    S_FBIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic                 done;
    logic [PROD_W-1:0]    quot;
    logic [BSIZE_W-1:0]   rem;
  } div_res_t;

endpackage

FILE: rtl/core/bba_div.sv
module bba_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bba_pkg::PROD_W-1:0]  dividend,
  input  logic [bba_pkg::BSIZE_W-1:0] divisor,
  output bba_pkg::div_res_t           res
);

  localparam int PW = bba_pkg::PROD_W;
  localparam int BW = bba_pkg::BSIZE_W;
  localparam int CW = $clog2(PW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] quo_r, quo_nxt;
  logic [BW-1:0] rem_r, rem_nxt;
  logic [BW-1:0] div_r, div_nxt;
  logic [BW:0]   shifted;
  logic          fits;

  assign shifted = {rem_r, quo_r[PW-1]};
  assign fits    = shifted >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[PW-2:0], fits};
      rem_nxt = fits ? BW'(shifted - {1'b0, div_r}) : BW'(shifted);
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(PW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quo_r;
  assign res.rem  = rem_r;

endmodule

FILE: rtl/core/bitmap_block_allocator_top.sv
// Fixed-size block allocator over a pool of up to NUM_BLOCKS equal blocks, one used bit per
// block held in a bit memory with one write and one read port. After reset the block sweeps
// that memory clear with in_tready low; configuration writes are taken during the sweep. One
// item is worked at a time. Allocate walks the used bits one per cycle from block zero,
// marks the first clear one as used and returns base + index * block_size + guard; it
// reports exhausted when no live block is clear, at once when the pool is empty. Free
// refuses an address outside the pool or inside the guard, else divides the pool offset
// less the guard by block_size in a radix-2 divider and clears the used bit of an aligned
// live block, refusing one already free. in_tready rises again as the result is loaded.
// Each result is held in an output register, so the next item is taken while it waits.
module bitmap_block_allocator_top #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
  parameter int ADDR_BITS  = bba_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] addr
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_addr
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW  = ADDR_BITS;
  localparam int PW  = bba_pkg::PROD_W;
  localparam int BW  = bba_pkg::BSIZE_W;
  localparam int OW  = (AW > PW) ? AW : PW;
  localparam int IW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CW  = $clog2(NUM_BLOCKS + 1);
  localparam int KW  = (CW > bba_pkg::BCNT_W) ? CW : bba_pkg::BCNT_W;

  logic [bba_pkg::BASE_W-1:0]  base_r;
  logic [BW-1:0]               bsize_r;
  logic [bba_pkg::GUARD_W-1:0] guard_r;
  logic [bba_pkg::BCNT_W-1:0]  bcnt_r;

  bba_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   scan_r, scan_nxt;
  logic            pend_vld_r, pend_vld_nxt;
  logic [IW-1:0]   pend_r, pend_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [1:0]      op_r, op_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [AW-1:0]   off_r, off_nxt;
  logic [PW-1:0]   size_r, size_nxt;
  logic [IW+BW-1:0] prod_r, prod_nxt;
  logic [AW-1:0]   res_r, res_nxt;
  logic [1:0]      stat_r, stat_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_data_r, out_data_nxt;
  logic [1:0]      out_user_r, out_user_nxt;

  logic            used_mem [NUM_BLOCKS];
  logic            rd_bit_r;
  logic [IW-1:0]   rd_idx;
  logic            mem_we;
  logic [IW-1:0]   mem_wa;
  logic            mem_wd;

  logic [KW-1:0]   live_k;
  logic [CW-1:0]   live;
  logic            cfg_wr;
  logic            in_pool;
  logic [AW-1:0]   rel;
  logic            div_start;
  bba_pkg::div_res_t div_res;

  assign live_k = (KW'(bcnt_r) > KW'(NUM_BLOCKS)) ? KW'(NUM_BLOCKS) : KW'(bcnt_r);
  assign live   = CW'(live_k);

  // configuration registers
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      bsize_r <= BW'(64);
      guard_r <= bba_pkg::GUARD_W'(4);
      bcnt_r  <= bba_pkg::BCNT_W'(64);
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        bba_pkg::REG_POOL_BASE:   base_r  <= cfg_pwdata;
        bba_pkg::REG_BLOCK_SIZE:  bsize_r <= cfg_pwdata[BW-1:0];
        bba_pkg::REG_GUARD_SIZE:  guard_r <= cfg_pwdata[bba_pkg::GUARD_W-1:0];
        bba_pkg::REG_BLOCK_COUNT: bcnt_r  <= cfg_pwdata[bba_pkg::BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      bba_pkg::REG_POOL_BASE:   cfg_prdata = base_r;
      bba_pkg::REG_BLOCK_SIZE:  cfg_prdata = 32'(bsize_r);
      bba_pkg::REG_GUARD_SIZE:  cfg_prdata = 32'(guard_r);
      bba_pkg::REG_BLOCK_COUNT: cfg_prdata = 32'(bcnt_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  // used-bit memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      used_mem[mem_wa] <= mem_wd;
    end
    rd_bit_r <= used_mem[rd_idx];
  end

  assign in_pool = OW'(off_r) < OW'(size_r);
  assign rel     = off_r - AW'(guard_r);

  bba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (PW'(rel)),
    .divisor  (bsize_r),
    .res      (div_res)
  );

  assign in_tready = (state_r == bba_pkg::S_IDLE);

  function automatic logic [PW-1:0] bcnt_r_live_prod(input logic [KW-1:0] cnt,
                                                     input logic [BW-1:0] bsz);
    logic [bba_pkg::BCNT_W-1:0] c7;
    c7 = bba_pkg::BCNT_W'(cnt);
    return c7 * bsz;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    pend_vld_nxt  = pend_vld_r;
    pend_nxt      = pend_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    off_nxt       = off_r;
    size_nxt      = size_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    rd_idx        = scan_r[IW-1:0];
    mem_we        = 1'b0;
    mem_wa        = scan_r[IW-1:0];
    mem_wd        = 1'b0;
    div_start     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      bba_pkg::S_CLR: begin
        mem_we   = 1'b1;
        scan_nxt = scan_r + 1'b1;
        if (scan_r == CW'(NUM_BLOCKS - 1)) begin
          state_nxt = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt       = in_tuser;
          addr_nxt     = AW'(in_tdata);
          res_nxt      = '0;
          scan_nxt     = '0;
          pend_vld_nxt = 1'b0;
          case (in_tuser)
            bba_pkg::OP_ALLOC: begin
              if (bsize_r == '0 || live == '0) begin
                stat_nxt  = bba_pkg::ST_EXHAUST;
                state_nxt = bba_pkg::S_RESP;
              end else begin
                state_nxt = bba_pkg::S_SCAN;
              end
            end
            bba_pkg::OP_FREE, bba_pkg::OP_CONTAINS: begin
              state_nxt = bba_pkg::S_OFFS;
            end
            default: begin
              stat_nxt  = bba_pkg::ST_REJECT;
              state_nxt = bba_pkg::S_RESP;
            end
          endcase
        end
      end
      bba_pkg::S_SCAN: begin
        if (pend_vld_r && !rd_bit_r) begin
          mem_we    = 1'b1;
          mem_wa    = pend_r;
          mem_wd    = 1'b1;
          idx_nxt   = pend_r;
          state_nxt = bba_pkg::S_AMUL;
        end else if (scan_r >= live) begin
          stat_nxt  = bba_pkg::ST_EXHAUST;
          state_nxt = bba_pkg::S_RESP;
        end else begin
          pend_nxt     = scan_r[IW-1:0];
          pend_vld_nxt = 1'b1;
          scan_nxt     = scan_r + 1'b1;
        end
      end
      bba_pkg::S_AMUL: begin
        prod_nxt  = idx_r * bsize_r;
        state_nxt = bba_pkg::S_AADD;
      end
      bba_pkg::S_AADD: begin
        res_nxt   = AW'(base_r) + AW'(prod_r) + AW'(guard_r);
        stat_nxt  = bba_pkg::ST_OK;
        state_nxt = bba_pkg::S_RESP;
      end
      bba_pkg::S_OFFS: begin
        off_nxt   = addr_r - AW'(base_r);
        size_nxt  = bcnt_r_live_prod(live_k, bsize_r);
        state_nxt = bba_pkg::S_RANGE;
      end
      bba_pkg::S_RANGE: begin
        if (op_r == bba_pkg::OP_CONTAINS) begin
          stat_nxt  = in_pool ? bba_pkg::ST_OK : bba_pkg::ST_NOT_POOL;
          state_nxt = bba_pkg::S_RESP;
        end else if (!in_pool) begin
          stat_nxt  = bba_pkg::ST_NOT_POOL;
          state_nxt = bba_pkg::S_RESP;
        end else if (off_r < AW'(guard_r)) begin
          stat_nxt  = bba_pkg::ST_REJECT;
          state_nxt = bba_pkg::S_RESP;
        end else begin
          div_start = 1'b1;
          state_nxt = bba_pkg::S_DIV;
        end
      end
      bba_pkg::S_DIV: begin
        if (div_res.done) begin
          if (div_res.rem != '0 || div_res.quot >= PW'(live)) begin
            stat_nxt  = bba_pkg::ST_REJECT;
            state_nxt = bba_pkg::S_RESP;
          end else begin
            idx_nxt   = IW'(div_res.quot);
            state_nxt = bba_pkg::S_FRD;
          end
        end
      end
      bba_pkg::S_FRD: begin
        rd_idx    = idx_r;
        state_nxt = bba_pkg::S_FBIT;
      end
      bba_pkg::S_FBIT: begin
        if (rd_bit_r) begin
          mem_we   = 1'b1;
          mem_wa   = idx_r;
          mem_wd   = 1'b0;
          stat_nxt = bba_pkg::ST_OK;
        end else begin
          stat_nxt = bba_pkg::ST_REJECT;
        end
        state_nxt = bba_pkg::S_RESP;
      end
      bba_pkg::S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = 32'(res_r);
          out_user_nxt  = stat_r;
          state_nxt     = bba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bba_pkg::S_CLR;
      scan_r      <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_r     <= pend_nxt;
    idx_r      <= idx_nxt;
    op_r       <= op_nxt;
    addr_r     <= addr_nxt;
    off_r      <= off_nxt;
    size_r     <= size_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r != bba_pkg::S_IDLE)
    else $error("accepted item did not start work");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == bba_pkg::S_DIV)
    else $error("divider finished outside the free sequence");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bba_pkg::S_RESP && stat_r != bba_pkg::ST_OK |-> res_r == '0)
    else $error("failed request carries an address");

endmodule

FILE: test/tb_bitmap_block_allocator_top.sv
`timescale 1ns / 1ps

module tb_bitmap_block_allocator_top;
  import bba_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int NUM_BLK = NUM_BLOCKS_DEF;
  localparam int SETTLE = 120;
  localparam int HOLD_CYCLES = 600;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] addr;
  } req_t;

  typedef struct packed {
    logic [31:0] result_addr;
    logic [1:0]  status;
  } rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bitmap_block_allocator_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // shadow of the allocator state
  logic [NUM_BLK-1:0] used_map = '0;
  logic [31:0] base_r = 32'd0;
  logic [15:0] bsize_r = 16'd64;
  logic [7:0]  guard_r = 8'd4;
  logic [6:0]  bcount_r = 7'd64;

  req_t ops_queue[$];
  rsp_t replies_due[$];
  int   ops_sent = 0;
  int   replies_seen = 0;
  int   mismatches = 0;
  int   cycle_count = 0;
  logic idle_on = 1'b1;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   tx_gap = 0;
  int   rx_gap = 0;

  initial forever #4 clk = ~clk;

  function automatic logic [6:0] live_blocks();
    return (bcount_r > 7'(NUM_BLK)) ? 7'(NUM_BLK) : bcount_r;
  endfunction

  function automatic logic [31:0] pool_span();
    return 32'(live_blocks()) * 32'(bsize_r);
  endfunction

  function automatic logic [31:0] payload_addr(input int unsigned j);
    return base_r + 32'(j) * 32'(bsize_r) + 32'(guard_r);
  endfunction

  function automatic rsp_t pool_response(input req_t r);
    rsp_t rs;
    logic [6:0] live;
    logic [31:0] span, off, rel, idx;
    logic found;
    live = live_blocks();
    span = pool_span();
    off = r.addr - base_r;
    found = 1'b0;
    rs.result_addr = '0;
    rs.status = ST_REJECT;
    case (r.opcode)
      OP_ALLOC: begin
        rs.status = ST_EXHAUST;
        if (bsize_r != 0) begin
          for (int k = 0; k < live; k++) begin
            if (!found && !used_map[k]) begin
              found = 1'b1;
              used_map[k] = 1'b1;
              rs.result_addr = payload_addr(k);
              rs.status = ST_OK;
            end
          end
        end
      end
      OP_FREE: begin
        if (off >= span) begin
          rs.status = ST_NOT_POOL;
        end else if (off >= 32'(guard_r)) begin
          rel = off - 32'(guard_r);
          if (rel % 32'(bsize_r) == 0) begin
            idx = rel / 32'(bsize_r);
            if (idx < 32'(live) && used_map[idx[5:0]]) begin
              used_map[idx[5:0]] = 1'b0;
              rs.status = ST_OK;
            end
          end
        end
      end
      OP_CONTAINS: rs.status = (off < span) ? ST_OK : ST_NOT_POOL;
      default: rs.status = ST_REJECT;
    endcase
    return rs;
  endfunction

  function automatic req_t random_op();
    req_t r;
    logic [6:0] live;
    logic [31:0] span;
    int pick;
    live = live_blocks();
    span = pool_span();
    pick = $urandom_range(0, 99);
    r.addr = $urandom();
    r.opcode = OP_FREE;
    if (pick < 36) begin
      r.opcode = OP_ALLOC;
    end else if (pick < 66) begin
      if (live != 0) r.addr = payload_addr($urandom_range(0, live - 1));
    end else if (pick < 72) begin
      if (live != 0) begin
        r.addr = payload_addr($urandom_range(0, live - 1));
        if ($urandom_range(0, 1) == 1) r.addr = r.addr + 32'($urandom_range(1, 3));
        else r.addr = r.addr - 32'($urandom_range(1, 3));
      end
    end else if (pick < 76) begin
      r.opcode = OP_FREE;
    end else if (pick < 86) begin
      r.opcode = OP_CONTAINS;
      if (span != 0) r.addr = base_r + 32'($urandom_range(0, span - 1));
    end else if (pick < 90) begin
      r.opcode = OP_CONTAINS;
      r.addr = base_r + span - 32'($urandom_range(0, 1));
    end else if (pick < 95) begin
      r.opcode = OP_CONTAINS;
    end else begin
      r.opcode = OP_UNUSED;
    end
    return r;
  endfunction

  task automatic push_op(input logic [1:0] op, input logic [31:0] a);
    ops_queue.push_back('{opcode: op, addr: a});
    ops_sent++;
  endtask

  task automatic push_random(input int n);
    for (int k = 0; k < n; k++) begin
      ops_queue.push_back(random_op());
      ops_sent++;
    end
  endtask

  task automatic drain();
    do @(posedge clk); while (replies_seen != ops_sent);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_POOL_BASE:   base_r = val;
      REG_BLOCK_SIZE:  bsize_r = val[15:0];
      REG_GUARD_SIZE:  guard_r = val[7:0];
      REG_BLOCK_COUNT: bcount_r = val[6:0];
      default: ;
    endcase
  endtask

  task automatic set_pool(input logic [31:0] b, input logic [31:0] bs, input logic [31:0] g,
                          input logic [31:0] n);
    reg_write(REG_POOL_BASE, b);
    reg_write(REG_BLOCK_SIZE, bs);
    reg_write(REG_GUARD_SIZE, g);
    reg_write(REG_BLOCK_COUNT, n);
  endtask

  task automatic flag(input string what, input logic [31:0] want_v, input logic [31:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    req_t nx;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        in_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        tx_gap <= $urandom_range(0, 12);
        in_tvalid <= 1'b0;
      end else if (ops_queue.size() != 0) begin
        nx = ops_queue.pop_front();
        in_tdata <= nx.addr;
        in_tuser <= nx.opcode;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap <= rx_gap - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_gap <= $urandom_range(0, 12);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (replies_due.size() == 0) begin
          flag("unexpected item", '0, out_tdata);
        end else begin
          want = replies_due.pop_front();
          if (out_tdata !== want.result_addr) flag("result_addr", want.result_addr, out_tdata);
          if (out_tuser !== want.status) flag("status", 32'(want.status), 32'(out_tuser));
          replies_seen <= replies_seen + 1;
        end
      end
      if (in_tvalid && in_tready)
        replies_due.push_back(pool_response('{opcode: in_tuser, addr: in_tdata}));
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry: base 0, 64-byte blocks, 4-byte guard, 64 blocks
    push_op(OP_CONTAINS, 32'h0000_0000);
    push_op(OP_CONTAINS, 32'h0000_0FFF);
    push_op(OP_CONTAINS, 32'h0000_1000);
    push_op(OP_CONTAINS, 32'hFFFF_FFFF);
    push_op(OP_FREE, 32'h0000_0004);
    push_op(OP_ALLOC, 32'hFFFF_FFFF);
    push_op(OP_ALLOC, 32'h0000_0000);
    push_op(OP_ALLOC, 32'h8000_0000);
    push_op(OP_FREE, 32'h0000_0044);
    push_op(OP_FREE, 32'h0000_0044);
    push_op(OP_FREE, 32'h0000_0000);
    push_op(OP_FREE, 32'h0000_0045);
    push_op(OP_FREE, 32'h0000_1388);
    push_op(OP_FREE, 32'hFFFF_FFFF);
    push_op(OP_ALLOC, 32'h0000_0000);
    push_op(OP_UNUSED, 32'hFFFF_FFFF);
    push_op(OP_UNUSED, 32'h0000_0000);
    push_random(300);
    drain();

    // single one-byte block at the top of the address space
    set_pool(32'hFFFF_FFFF, 32'd1, 32'd0, 32'd1);
    push_op(OP_ALLOC, 32'h0000_0000);
    push_op(OP_ALLOC, 32'h0000_0000);
    push_op(OP_CONTAINS, 32'h0000_0000);
    push_op(OP_FREE, 32'hFFFF_FFFF);
    push_random(100);
    drain();

    // widest blocks and guard, count saturates, pool wraps past zero
    set_pool(32'hFFFF_F000, 32'd65535, 32'd255, 32'd127);
    hold_req <= hold_req + 1;
    push_random(300);
    drain();

    // guard larger than the block
    set_pool(32'h0000_1000, 32'd8, 32'd20, 32'd40);
    push_random(250);
    drain();

    // empty pool: zero block size, then zero block count
    reg_write(REG_BLOCK_SIZE, 32'd0);
    push_random(60);
    drain();
    reg_write(REG_BLOCK_SIZE, 32'd48);
    reg_write(REG_BLOCK_COUNT, 32'd0);
    push_random(60);
    drain();

    set_pool(32'h0000_0000, 32'd16, 32'd0, 32'd64);
    push_random(200);
    drain();
    reg_write(REG_BLOCK_COUNT, 32'd3);
    push_random(100);
    drain();

    reg_write(REG_BLOCK_COUNT, 32'd64);
    idle_on <= 1'b0;
    push_random(180);
    drain();

    if (mismatches == 0 && replies_due.size() == 0 && ops_queue.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/bba_pkg.sv
rtl/core/bba_div.sv
rtl/core/bitmap_block_allocator_top.sv
test/tb_bitmap_block_allocator_top.sv
